// File: src/next_k_permutation_generator_assert.svh
`ifndef NEXT_K_PERMUTATION_GENERATOR_ASSERT_SVH
`define NEXT_K_PERMUTATION_GENERATOR_ASSERT_SVH

// same-cycle implication, reset masked
`define NKPG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("next_k_permutation_generator check failed");

// next-cycle implication, reset masked
`define NKPG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next_k_permutation_generator check failed");

`endif

// File: src/nkpg_pkg.sv
package nkpg_pkg;

  localparam int unsigned ArrangeMax = 16;
  localparam int unsigned KindW      = 2;
  localparam int unsigned ElemW      = 8;
  localparam int unsigned KW         = 5;
  localparam int unsigned PosW       = 4;
  localparam int unsigned StatW      = 2;

  localparam logic [KindW-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KindW-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KindW-1:0] KIND_START = 2'd2;
  localparam logic [KindW-1:0] KIND_NEXT  = 2'd3;

  localparam logic [StatW-1:0] ST_VALUE     = 2'd0;
  localparam logic [StatW-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [StatW-1:0] ST_ACK       = 2'd2;
  localparam logic [StatW-1:0] ST_FULL      = 2'd3;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_START,
    DP_NEXT_INIT,
    DP_REL,
    DP_SCAN_STEP,
    DP_TAKE,
    DP_FILL_TAKE,
    DP_SLOT_DEC,
    DP_EXHAUST,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic             emit_st;
    logic [StatW-1:0] st;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic k0_zero;
    logic gen_ok;
    logic scan_end;
    logic flag_free;
    logic slot_zero;
    logic fill_done;
    logic emit_last;
  } sts_t;

endpackage

// File: src/next_k_permutation_generator.sv
// Lexicographic next-k-permutation generator. Load, clear, a start with nothing to arrange and
// a next outside generation give one result in the cycle after the transfer. A start with count
// k sets up the chosen indices and then gives the k values in consecutive cycles. A next frees
// chosen slots from the right and scans the free flags one index per cycle, ending with the k
// values or an exhausted status; this scan sets the rate. Results of one transfer come in
// consecutive cycles with valid_o high and must be taken as they appear, as there is no
// backpressure. busy is high while a transfer is being worked on; start is ignored then.
module next_k_permutation_generator #(
  parameter int unsigned MAX_ELEMENTS = 16,
  parameter int unsigned VALUE_WIDTH  = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [nkpg_pkg::KindW-1:0]  kind_i,
  input  logic [nkpg_pkg::ElemW-1:0]  value_i,
  input  logic [nkpg_pkg::KW-1:0]     select_count_i,
  output logic                        busy,
  output logic                        valid_o,
  output logic [nkpg_pkg::ElemW-1:0]  element_value_o,
  output logic [nkpg_pkg::PosW-1:0]   position_o,
  output logic                        last_o,
  output logic [nkpg_pkg::StatW-1:0]  status_o
);
  import nkpg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nkpg_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  nkpg_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .value_i         (value_i),
    .select_count_i  (select_count_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .valid_o         (valid_o),
    .element_value_o (element_value_o),
    .position_o      (position_o),
    .last_o          (last_o),
    .status_o        (status_o)
  );

endmodule

// File: src/nkpg_datapath.sv
module nkpg_datapath #(
  parameter int unsigned MAX_ELEMENTS = 16,
  parameter int unsigned VALUE_WIDTH  = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [nkpg_pkg::ElemW-1:0]  value_i,
  input  logic [nkpg_pkg::KW-1:0]     select_count_i,
  input  nkpg_pkg::cmd_t              cmd_i,
  output nkpg_pkg::sts_t              sts_o,
  output logic                        valid_o,
  output logic [nkpg_pkg::ElemW-1:0]  element_value_o,
  output logic [nkpg_pkg::PosW-1:0]   position_o,
  output logic                        last_o,
  output logic [nkpg_pkg::StatW-1:0]  status_o
);
  import nkpg_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SW = (VALUE_WIDTH < ElemW) ? VALUE_WIDTH : ElemW;
  localparam int unsigned WW = (CW > KW) ? CW : KW;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ELEMENTS);

  logic [SW-1:0]           mem_q [MAX_ELEMENTS];
  logic [SW-1:0]           rdata_q;
  logic [MAX_ELEMENTS-1:0] free_q;
  logic [IW-1:0]           chosen_q [ArrangeMax];
  logic [CW-1:0]           loaded_q;
  logic [KW-1:0]           arranged_q;
  logic                    gen_q;
  logic [CW-1:0]           j_q;
  logic [PosW-1:0]         slot_q;
  logic [KW-1:0]           r_q;
  logic [PosW-1:0]         pos_q;
  logic                    ovalid_q;
  logic [PosW-1:0]         opos_q;
  logic                    olast_q;
  logic [StatW-1:0]        ost_q;

  logic [WW-1:0]           sel_w, ld_w, kmin_w;
  logic [KW-1:0]           k0;
  logic [KW-1:0]           km1;
  logic [PosW-1:0]         rd_sel;
  logic [IW-1:0]           ch_rd;
  logic [IW-1:0]           fidx;
  logic [MAX_ELEMENTS-1:0] start_mask;
  logic                    scan_end;

  always_comb begin
    sel_w  = WW'(select_count_i);
    ld_w   = WW'(loaded_q);
    kmin_w = (sel_w < ld_w) ? sel_w : ld_w;
    k0     = (kmin_w > WW'(ArrangeMax)) ? KW'(ArrangeMax) : kmin_w[KW-1:0];
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      start_mask[i] = !(WW'(i) < WW'(k0));
    end
  end

  assign km1      = arranged_q - KW'(1);
  assign rd_sel   = (cmd_i.op == DP_EMIT) ? pos_q : slot_q;
  assign ch_rd    = chosen_q[rd_sel];
  assign scan_end = (j_q >= loaded_q);
  assign fidx     = scan_end ? '0 : j_q[IW-1:0];

  assign sts_o.full      = (loaded_q >= MaxCnt);
  assign sts_o.k0_zero   = (k0 == '0);
  assign sts_o.gen_ok    = gen_q && (arranged_q != '0);
  assign sts_o.scan_end  = scan_end;
  assign sts_o.flag_free = free_q[j_q[IW-1:0]];
  assign sts_o.slot_zero = (slot_q == '0);
  assign sts_o.fill_done = (r_q >= arranged_q);
  assign sts_o.emit_last = ({1'b0, pos_q} == km1);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q     <= '1;
      loaded_q   <= '0;
      arranged_q <= '0;
      gen_q      <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        DP_LOAD: begin
          free_q[loaded_q[IW-1:0]] <= 1'b1;
          loaded_q                 <= loaded_q + CW'(1);
          gen_q                    <= 1'b0;
        end
        DP_CLEAR: begin
          free_q     <= '1;
          loaded_q   <= '0;
          arranged_q <= '0;
          gen_q      <= 1'b0;
        end
        DP_START: begin
          free_q     <= start_mask;
          arranged_q <= k0;
          gen_q      <= (k0 != '0);
        end
        DP_REL:       free_q[ch_rd]          <= 1'b1;
        DP_TAKE:      free_q[j_q[IW-1:0]]    <= 1'b0;
        DP_FILL_TAKE: free_q[fidx]           <= 1'b0;
        DP_EXHAUST: begin
          free_q <= '1;
          gen_q  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // scan counters and chosen indices
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_START: begin
        for (int i = 0; i < ArrangeMax; i++) begin
          chosen_q[i] <= IW'(i);
        end
        pos_q <= '0;
      end
      DP_NEXT_INIT: slot_q <= km1[PosW-1:0];
      DP_REL:       j_q    <= CW'(ch_rd) + CW'(1);
      DP_SCAN_STEP: j_q    <= j_q + CW'(1);
      DP_TAKE: begin
        chosen_q[slot_q] <= j_q[IW-1:0];
        r_q              <= KW'(slot_q) + KW'(1);
        j_q              <= '0;
        pos_q            <= '0;
      end
      DP_FILL_TAKE: begin
        chosen_q[r_q[PosW-1:0]] <= fidx;
        r_q                     <= r_q + KW'(1);
        j_q                     <= j_q + CW'(1);
      end
      DP_SLOT_DEC: slot_q <= slot_q - PosW'(1);
      DP_EMIT:     pos_q  <= pos_q + PosW'(1);
      default: ;
    endcase
  end

  // element store
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) begin
      mem_q[loaded_q[IW-1:0]] <= value_i[SW-1:0];
    end
    rdata_q <= mem_q[ch_rd];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      opos_q   <= '0;
      olast_q  <= 1'b0;
      ost_q    <= ST_VALUE;
    end else begin
      priority if (cmd_i.op == DP_EMIT) begin
        ovalid_q <= 1'b1;
        opos_q   <= pos_q;
        olast_q  <= sts_o.emit_last;
        ost_q    <= ST_VALUE;
      end else if (cmd_i.emit_st) begin
        ovalid_q <= 1'b1;
        opos_q   <= '0;
        olast_q  <= 1'b1;
        ost_q    <= cmd_i.st;
      end else begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign valid_o         = ovalid_q;
  assign element_value_o = (ost_q == ST_VALUE) ? ElemW'(rdata_q) : '0;
  assign position_o      = opos_q;
  assign last_o          = olast_q;
  assign status_o        = ost_q;

endmodule

// File: src/nkpg_controller.sv
module nkpg_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic [nkpg_pkg::KindW-1:0] kind_i,
  input  nkpg_pkg::sts_t             sts_i,
  output nkpg_pkg::cmd_t             cmd_o,
  output logic                       busy
);
  import nkpg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REL  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = DP_NOP;
    cmd_o.emit_st = 1'b0;
    cmd_o.st      = ST_VALUE;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KIND_LOAD: begin
              cmd_o.emit_st = 1'b1;
              if (sts_i.full) begin
                cmd_o.st = ST_FULL;
              end else begin
                cmd_o.op = DP_LOAD;
                cmd_o.st = ST_ACK;
              end
            end
            KIND_CLEAR: begin
              cmd_o.op      = DP_CLEAR;
              cmd_o.emit_st = 1'b1;
              cmd_o.st      = ST_ACK;
            end
            KIND_START: begin
              cmd_o.op = DP_START;
              if (sts_i.k0_zero) begin
                cmd_o.emit_st = 1'b1;
                cmd_o.st      = ST_EXHAUSTED;
              end else begin
                state_d = S_EMIT;
              end
            end
            KIND_NEXT: begin
              if (!sts_i.gen_ok) begin
                cmd_o.emit_st = 1'b1;
                cmd_o.st      = ST_EXHAUSTED;
              end else begin
                cmd_o.op = DP_NEXT_INIT;
                state_d  = S_REL;
              end
            end
          endcase
        end
      end
      S_REL: begin
        cmd_o.op = DP_REL;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        priority if (sts_i.scan_end) begin
          if (sts_i.slot_zero) begin
            cmd_o.op      = DP_EXHAUST;
            cmd_o.emit_st = 1'b1;
            cmd_o.st      = ST_EXHAUSTED;
            state_d       = S_IDLE;
          end else begin
            cmd_o.op = DP_SLOT_DEC;
            state_d  = S_REL;
          end
        end else if (sts_i.flag_free) begin
          cmd_o.op = DP_TAKE;
          state_d  = S_FILL;
        end else begin
          cmd_o.op = DP_SCAN_STEP;
        end
      end
      S_FILL: begin
        priority if (sts_i.fill_done) begin
          cmd_o.op = DP_EMIT;
          state_d  = sts_i.emit_last ? S_IDLE : S_EMIT;
        end else if (sts_i.scan_end || sts_i.flag_free) begin
          cmd_o.op = DP_FILL_TAKE;
        end else begin
          cmd_o.op = DP_SCAN_STEP;
        end
      end
      S_EMIT: begin
        cmd_o.op = DP_EMIT;
        if (sts_i.emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/nkpg_checker.sv
`include "next_k_permutation_generator_assert.svh"

module nkpg_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        valid_o,
  input logic [nkpg_pkg::ElemW-1:0]  element_value_o,
  input logic [nkpg_pkg::PosW-1:0]   position_o,
  input logic                        last_o,
  input logic [nkpg_pkg::StatW-1:0]  status_o
);
  import nkpg_pkg::*;

  // every transfer answers at once or keeps the block busy
  `NKPG_ASSERT_NXT(a_accept_answer, start && !busy, valid_o || busy)
  // status results stand alone
  `NKPG_ASSERT_IMP(a_status_last, valid_o && status_o != ST_VALUE, last_o)
  `NKPG_ASSERT_IMP(a_status_zero, valid_o && status_o != ST_VALUE, element_value_o == '0 && position_o == '0)
  // arrangement values come back to back in position order
  `NKPG_ASSERT_NXT(a_pos_step, valid_o && !last_o, valid_o && position_o == $past(position_o) + 4'd1)

endmodule

bind next_k_permutation_generator nkpg_checker u_nkpg_checker (.*);

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nkpg_pkg::*;

  localparam int unsigned MaxElems   = 16;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned TailCycles = 400;
  localparam int unsigned QuietItems = 25;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [ElemW-1:0] value;
    logic [KW-1:0]    count;
    bit               drain;
  } op_item_t;

  typedef struct packed {
    logic [ElemW-1:0] value;
    logic [PosW-1:0]  pos;
    logic             last;
    logic [StatW-1:0] st;
  } arr_word_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic [KindW-1:0] kind_i;
  logic [ElemW-1:0] value_i;
  logic [KW-1:0]    select_count_i;
  logic             busy;
  logic             valid_o;
  logic [ElemW-1:0] element_value_o;
  logic [PosW-1:0]  position_o;
  logic             last_o;
  logic [StatW-1:0] status_o;

  op_item_t  op_q[$];
  arr_word_t arr_exp_q[$];

  // predictor state
  logic [ElemW-1:0] elem_store[MaxElems];
  bit               free_flag[MaxElems];
  int unsigned      pick_idx[ArrangeMax];
  int unsigned      n_loaded;
  int unsigned      k_cnt;
  bit               gen_on;

  bit          xfer_seen;
  int unsigned idle_left;
  int unsigned fail_cnt;
  int unsigned cyc_cnt;

  next_k_permutation_generator #(
    .MAX_ELEMENTS(MaxElems),
    .VALUE_WIDTH (ElemW)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .select_count_i (select_count_i),
    .busy           (busy),
    .valid_o        (valid_o),
    .element_value_o(element_value_o),
    .position_o     (position_o),
    .last_o         (last_o),
    .status_o       (status_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned first_free(int unsigned from);
    int unsigned j;
    for (j = from; j < n_loaded; j++) begin
      if (free_flag[j]) return j;
    end
    return n_loaded;
  endfunction

  function automatic void release_all();
    int unsigned j;
    for (j = 0; j < MaxElems; j++) free_flag[j] = 1'b1;
  endfunction

  function automatic void push_word(logic [ElemW-1:0] value, int unsigned pos, bit last,
                                    logic [StatW-1:0] st);
    arr_word_t w;
    w.value = value;
    w.pos   = pos[PosW-1:0];
    w.last  = last;
    w.st    = st;
    arr_exp_q.insert(arr_exp_q.size(), w);
  endfunction

  function automatic void push_arrangement();
    int unsigned j;
    for (j = 0; j < k_cnt; j++) push_word(elem_store[pick_idx[j]], j, j + 1 == k_cnt, ST_VALUE);
  endfunction

  function automatic void predict_arrangement(logic [KindW-1:0] kind, logic [ElemW-1:0] value,
                                              logic [KW-1:0] count);
    int unsigned k;
    int unsigned slot;
    int unsigned cur;
    int unsigned nxt;
    int unsigned r;
    int unsigned f;
    bit          found;
    case (kind)
      KIND_LOAD: begin
        if (n_loaded >= MaxElems) begin
          push_word('0, 0, 1'b1, ST_FULL);
        end else begin
          elem_store[n_loaded] = value;
          free_flag[n_loaded] = 1'b1;
          n_loaded++;
          gen_on = 1'b0;
          push_word('0, 0, 1'b1, ST_ACK);
        end
      end
      KIND_CLEAR: begin
        n_loaded = 0;
        k_cnt = 0;
        gen_on = 1'b0;
        release_all();
        push_word('0, 0, 1'b1, ST_ACK);
      end
      KIND_START: begin
        release_all();
        k = count;
        if (k > n_loaded) k = n_loaded;
        if (k > ArrangeMax) k = ArrangeMax;
        k_cnt = k;
        if (k == 0) begin
          gen_on = 1'b0;
          push_word('0, 0, 1'b1, ST_EXHAUSTED);
        end else begin
          for (r = 0; r < k; r++) begin
            pick_idx[r] = r;
            free_flag[r] = 1'b0;
          end
          gen_on = 1'b1;
          push_arrangement();
        end
      end
      default: begin
        if (!gen_on || k_cnt == 0) begin
          push_word('0, 0, 1'b1, ST_EXHAUSTED);
        end else begin
          found = 1'b0;
          slot = k_cnt;
          while (slot > 0 && !found) begin
            slot--;
            cur = pick_idx[slot];
            free_flag[cur] = 1'b1;
            nxt = first_free(cur + 1);
            if (nxt < n_loaded) begin
              pick_idx[slot] = nxt;
              free_flag[nxt] = 1'b0;
              for (r = slot + 1; r < k_cnt; r++) begin
                f = first_free(0);
                pick_idx[r] = f;
                free_flag[f] = 1'b0;
              end
              found = 1'b1;
            end
          end
          if (found) begin
            push_arrangement();
          end else begin
            gen_on = 1'b0;
            release_all();
            push_word('0, 0, 1'b1, ST_EXHAUSTED);
          end
        end
      end
    endcase
  endfunction

  task automatic add_op(logic [KindW-1:0] kind, logic [ElemW-1:0] value, logic [KW-1:0] count,
                        bit drain);
    op_item_t it;
    it.kind  = kind;
    it.value = value;
    it.count = count;
    it.drain = drain;
    op_q.insert(op_q.size(), it);
  endtask

  // prediction on each transfer, then result check
  always @(posedge clk_i) begin : mon
    arr_word_t got;
    arr_word_t want;
    xfer_seen = rst_ni && start && !busy;
    if (xfer_seen) predict_arrangement(kind_i, value_i, select_count_i);
    if (rst_ni && valid_o) begin
      got = {element_value_o, position_o, last_o, status_o};
      if (arr_exp_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: value %0d pos %0d last %0d status %0d",
                   got.value, got.pos, got.last, got.st);
      end else begin
        want = arr_exp_q.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: exp value %0d pos %0d last %0d status %0d, got %0d %0d %0d %0d",
                     want.value, want.pos, want.last, want.st,
                     got.value, got.pos, got.last, got.st);
        end
      end
    end
  end

  always @(negedge clk_i) begin : drv
    op_item_t it;
    logic     go;
    go = start;
    if (rst_ni && (!start || xfer_seen)) begin
      go = 1'b0;
      if (idle_left != 0) begin
        idle_left--;
      end else if (op_q.size() != 0 && !(op_q[0].drain && arr_exp_q.size() != 0)) begin
        it = op_q.pop_front();
        kind_i <= it.kind;
        value_i <= it.value;
        select_count_i <= it.count;
        go = 1'b1;
        if (op_q.size() >= QuietItems && $urandom_range(0, 3) == 0)
          idle_left = $urandom_range(1, 11);
      end
    end
    start <= go;
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : run
    int unsigned i;
    int unsigned n;
    int unsigned k;
    int unsigned m;
    int unsigned added;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = KIND_LOAD;
    value_i = '0;
    select_count_i = '0;
    n_loaded = 0;
    k_cnt = 0;
    gen_on = 1'b0;
    release_all();

    // directed part
    add_op(KIND_NEXT, 8'h00, 5'd0, 1'b0);
    add_op(KIND_START, 8'h00, 5'd3, 1'b0);
    for (i = 0; i < MaxElems; i++)
      add_op(KIND_LOAD, (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom_range(0, 255)),
             5'd0, 1'b0);
    add_op(KIND_LOAD, 8'hAA, 5'd0, 1'b0);
    add_op(KIND_START, 8'h00, 5'd31, 1'b0);
    add_op(KIND_NEXT, 8'hFF, 5'd31, 1'b0);
    add_op(KIND_START, 8'h00, 5'd0, 1'b0);
    add_op(KIND_CLEAR, 8'h55, 5'd16, 1'b1);
    add_op(KIND_NEXT, 8'h00, 5'd0, 1'b0);
    add_op(KIND_LOAD, 8'h0F, 5'd0, 1'b0);

    // random part: mostly load / start / next runs
    added = 0;
    while (added < 150) begin
      if ($urandom_range(0, 9) < 7) begin
        if (added == 0 || $urandom_range(0, 4) != 0) begin
          add_op(KIND_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                 added == 0 || $urandom_range(0, 9) == 0);
          added++;
        end
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 17) : $urandom_range(1, 4);
        for (i = 0; i < n; i++)
          add_op(KIND_LOAD, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), 1'b0);
        k = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, n);
        add_op(KIND_START, 8'($urandom_range(0, 255)), 5'(k), 1'b0);
        m = $urandom_range(0, 12);
        for (i = 0; i < m; i++) begin
          if ($urandom_range(0, 19) == 0)
            add_op(KIND_LOAD, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), 1'b0);
          else
            add_op(KIND_NEXT, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), 1'b0);
        end
        added += n + m + 1;
      end else begin
        add_op(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
               5'($urandom_range(0, 31)), 1'b0);
        added++;
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (op_q.size() != 0 || start) @(posedge clk_i);
    while (arr_exp_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_cnt == 0 && arr_exp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
